// ----- hw/rtl/cgps_pkg.sv -----
// Shared types, sizes, request codes and saturating helpers for the complex solver.
// Depends on nothing; the core, the multiplier, the divider and the testbench import it.
package cgps_pkg;

    localparam int MAX_SIZE  = 16;
    localparam int FRAC_W    = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_SIZE);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int CELLS     = MAX_SIZE * MAX_SIZE;
    localparam int WORD_W    = 2 * DATA_W;
    localparam int SUM_W     = WORD_W + 1;
    localparam int DIV_STEPS = WORD_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int SIZE_W    = 5;
    localparam int OP_W      = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SIZE);

    localparam logic [OP_W-1:0] OP_WR_MAT = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_RHS = 2'd1;
    localparam logic [OP_W-1:0] OP_SOLVE  = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] im;
        logic signed [DATA_W-1:0] re;
    } cplx_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] s1;
        logic signed [SUM_W-1:0] s2;
    } mul_res_t;

    function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]))
            r = v[DATA_W-1:0];
        else if (v[SUM_W-1])
            r = {1'b1, {(DATA_W-1){1'b0}}};
        else
            r = {1'b0, {(DATA_W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] shift_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = v >>> FRAC_W;
        return sat_word(t);
    endfunction

    function automatic logic signed [DATA_W-1:0] sub_sat(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        return sat_word({{(SUM_W-DATA_W-1){d[DATA_W]}}, d});
    endfunction

    function automatic cplx_t csub(input cplx_t a, input cplx_t b);
        cplx_t r;
        r.re = sub_sat(a.re, b.re);
        r.im = sub_sat(a.im, b.im);
        return r;
    endfunction

endpackage

// ----- hw/rtl/complex_gauss_partial_pivot_solve_core.sv -----
// Top level of the complex solver: request decode, store memories and the solve sequencer.
// Instantiates cgps_cmul and cgps_cdiv; uses cgps_pkg.
//
//  channel | direction | contents
//  s_*     | in        | tuser: operation; tdata: row, column, value_real, value_imag
//  m_*     | out       | tuser: singular; tlast: last; tdata: index, solution_real, solution_imag
//  cfg_*   | in        | size_in_use, written when cfg_we is high
//
// A solve request is paced by the single-port matrix memory, the shared complex multiplier
// and the bit-serial divider, which performs n*(n-1)/2 + n divisions.
// Reset clears the sequencer and the output valid flag; store contents are undefined until
// written. A stalled result holds the sequencer; a final result waiting does not block
// the next request.
module complex_gauss_partial_pivot_solve_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [71:0]                  s_tdata,   // row, column, value_real, value_imag
    input  logic [cgps_pkg::OP_W-1:0]    s_tuser,   // operation
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [71:0]                  m_tdata,   // index, solution_real, solution_imag, zeros
    output logic [0:0]                   m_tuser,   // singular
    output logic                         m_tlast,
    input  logic                         cfg_we,
    input  logic [cgps_pkg::SIZE_W-1:0]  cfg_wdata
);
    import cgps_pkg::*;

    localparam logic [5:0] ST_IDLE   = 6'd0;
    localparam logic [5:0] ST_PV_RD  = 6'd1;
    localparam logic [5:0] ST_PV_WT  = 6'd2;
    localparam logic [5:0] ST_PV_MG  = 6'd3;
    localparam logic [5:0] ST_PV_END = 6'd4;
    localparam logic [5:0] ST_SW_RA  = 6'd5;
    localparam logic [5:0] ST_SW_RB  = 6'd6;
    localparam logic [5:0] ST_SW_WA  = 6'd7;
    localparam logic [5:0] ST_SW_WB  = 6'd8;
    localparam logic [5:0] ST_SR_RA  = 6'd9;
    localparam logic [5:0] ST_SR_RB  = 6'd10;
    localparam logic [5:0] ST_SR_WA  = 6'd11;
    localparam logic [5:0] ST_SR_WB  = 6'd12;
    localparam logic [5:0] ST_EL_PIV = 6'd13;
    localparam logic [5:0] ST_EL_PW  = 6'd14;
    localparam logic [5:0] ST_EL_DEN = 6'd15;
    localparam logic [5:0] ST_EL_RD  = 6'd16;
    localparam logic [5:0] ST_EL_FW  = 6'd17;
    localparam logic [5:0] ST_EL_FN  = 6'd18;
    localparam logic [5:0] ST_EL_FD  = 6'd19;
    localparam logic [5:0] ST_EL_AR  = 6'd20;
    localparam logic [5:0] ST_EL_AW  = 6'd21;
    localparam logic [5:0] ST_EL_AM  = 6'd22;
    localparam logic [5:0] ST_EL_AS  = 6'd23;
    localparam logic [5:0] ST_EL_BR  = 6'd24;
    localparam logic [5:0] ST_EL_BW  = 6'd25;
    localparam logic [5:0] ST_EL_BM  = 6'd26;
    localparam logic [5:0] ST_EL_BS  = 6'd27;
    localparam logic [5:0] ST_K_NEXT = 6'd28;
    localparam logic [5:0] ST_BK_RB  = 6'd29;
    localparam logic [5:0] ST_BK_VW  = 6'd30;
    localparam logic [5:0] ST_BK_AR  = 6'd31;
    localparam logic [5:0] ST_BK_AW  = 6'd32;
    localparam logic [5:0] ST_BK_AM  = 6'd33;
    localparam logic [5:0] ST_BK_DR  = 6'd34;
    localparam logic [5:0] ST_BK_DW  = 6'd35;
    localparam logic [5:0] ST_BK_DM  = 6'd36;
    localparam logic [5:0] ST_BK_DN  = 6'd37;
    localparam logic [5:0] ST_BK_DD  = 6'd38;
    localparam logic [5:0] ST_OUT_RD = 6'd39;
    localparam logic [5:0] ST_OUT_WT = 6'd40;
    localparam logic [5:0] ST_SING   = 6'd41;

    // control state
    logic [5:0]        state_reg, state_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  r_reg, r_next;
    logic [IDX_W-1:0]  e_reg, e_next;
    logic [IDX_W-1:0]  br_reg, br_next;
    logic [IDX_W-1:0]  nl_reg, nl_next;
    logic [SIZE_W-1:0] size_reg;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [WORD_W-1:0] best_reg, best_next;
    logic [WORD_W-1:0] t1_reg, t1_next;
    logic [WORD_W-1:0] den_reg, den_next;
    cplx_t             piv_reg, piv_next;
    cplx_t             f_reg, f_next;
    cplx_t             v_reg, v_next;
    cplx_t             dv_reg, dv_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    cplx_t             out_val_reg, out_val_next;
    logic              out_sing_reg, out_sing_next;
    logic              out_last_reg, out_last_next;

    // memories
    logic [WORD_W-1:0] mat_mem [CELLS];
    logic [WORD_W-1:0] rhs_mem [MAX_SIZE];
    logic [WORD_W-1:0] sol_mem [MAX_SIZE];
    logic [WORD_W-1:0] mat_q_reg, rhs_q_reg, sol_q_reg;
    logic              mat_re, mat_we, rhs_re, rhs_we, sol_re, sol_we;
    logic [ADDR_W-1:0] mat_addr;
    logic [IDX_W-1:0]  rhs_addr, sol_addr;
    logic [WORD_W-1:0] mat_wd, rhs_wd, sol_wd;

    // arithmetic units
    logic      cm_start, cm_conj, cm_done;
    cplx_t     cm_a, cm_b;
    mul_res_t  cm_res;
    cplx_t     prod;
    logic      dv_start, dv_done;
    cplx_t     dv_q;

    logic              accept;
    logic              slot_free;
    logic [IDX_W-1:0]  req_row, req_col;
    cplx_t             req_val;
    logic [IDX_W-1:0]  n_last;

    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign req_row   = s_tdata[3:0];
    assign req_col   = s_tdata[7:4];
    assign req_val   = {s_tdata[71:40], s_tdata[39:8]};
    assign prod.re   = shift_sat(cm_res.s1);
    assign prod.im   = shift_sat(cm_res.s2);

    always_comb
    begin
        if (size_reg == '0)
            n_last = '0;
        else if (size_reg > SIZE_MAX)
            n_last = IDX_W'(MAX_SIZE - 1);
        else
            n_last = IDX_W'(size_reg - 1'b1);
    end

    cgps_cmul u_cmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cm_start),
        .conj  (cm_conj),
        .a     (cm_a),
        .b     (cm_b),
        .done  (cm_done),
        .res   (cm_res)
    );

    cgps_cdiv u_cdiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (dv_start),
        .num_re (cm_res.s1),
        .num_im (cm_res.s2),
        .den    (den_reg),
        .done   (dv_done),
        .q      (dv_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        r_next         = r_reg;
        e_next         = e_reg;
        br_next        = br_reg;
        nl_next        = nl_reg;
        out_valid_next = out_valid_reg && !m_tready;
        best_next      = best_reg;
        t1_next        = t1_reg;
        den_next       = den_reg;
        piv_next       = piv_reg;
        f_next         = f_reg;
        v_next         = v_reg;
        dv_next        = dv_reg;
        out_idx_next   = out_idx_reg;
        out_val_next   = out_val_reg;
        out_sing_next  = out_sing_reg;
        out_last_next  = out_last_reg;
        s_tready       = 1'b0;
        mat_re   = 1'b0;
        mat_we   = 1'b0;
        mat_addr = {r_reg, k_reg};
        mat_wd   = mat_q_reg;
        rhs_re   = 1'b0;
        rhs_we   = 1'b0;
        rhs_addr = r_reg;
        rhs_wd   = rhs_q_reg;
        sol_re   = 1'b0;
        sol_we   = 1'b0;
        sol_addr = r_reg;
        sol_wd   = dv_q;
        cm_start = 1'b0;
        cm_conj  = 1'b1;
        cm_a     = mat_q_reg;
        cm_b     = mat_q_reg;
        dv_start = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (s_tuser)
                        OP_WR_MAT:
                        begin
                            mat_we   = 1'b1;
                            mat_addr = {req_row, req_col};
                            mat_wd   = req_val;
                        end
                        OP_WR_RHS:
                        begin
                            rhs_we   = 1'b1;
                            rhs_addr = req_row;
                            rhs_wd   = req_val;
                        end
                        OP_SOLVE:
                        begin
                            nl_next    = n_last;
                            k_next     = '0;
                            r_next     = '0;
                            br_next    = '0;
                            best_next  = '0;
                            state_next = ST_PV_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PV_RD:
            begin
                mat_re     = 1'b1;
                mat_addr   = {r_reg, k_reg};
                state_next = ST_PV_WT;
            end
            ST_PV_WT:
            begin
                cm_start   = 1'b1;
                state_next = ST_PV_MG;
            end
            ST_PV_MG:
            begin
                if (cm_done)
                begin
                    if (cm_res.s1[WORD_W-1:0] > best_reg)
                    begin
                        best_next = cm_res.s1[WORD_W-1:0];
                        br_next   = r_reg;
                    end
                    if (r_reg == nl_reg)
                        state_next = ST_PV_END;
                    else
                    begin
                        r_next     = r_reg + 1'b1;
                        state_next = ST_PV_RD;
                    end
                end
            end
            ST_PV_END:
            begin
                e_next = k_reg;
                priority if (best_reg == '0)
                    state_next = ST_SING;
                else if (br_reg != k_reg)
                    state_next = ST_SW_RA;
                else
                    state_next = ST_EL_PIV;
            end
            ST_SW_RA:
            begin
                mat_re     = 1'b1;
                mat_addr   = {k_reg, e_reg};
                state_next = ST_SW_RB;
            end
            ST_SW_RB:
            begin
                mat_re     = 1'b1;
                mat_addr   = {br_reg, e_reg};
                t1_next    = mat_q_reg;
                state_next = ST_SW_WA;
            end
            ST_SW_WA:
            begin
                mat_we     = 1'b1;
                mat_addr   = {k_reg, e_reg};
                mat_wd     = mat_q_reg;
                state_next = ST_SW_WB;
            end
            ST_SW_WB:
            begin
                mat_we   = 1'b1;
                mat_addr = {br_reg, e_reg};
                mat_wd   = t1_reg;
                if (e_reg == nl_reg)
                    state_next = ST_SR_RA;
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_SW_RA;
                end
            end
            ST_SR_RA:
            begin
                rhs_re     = 1'b1;
                rhs_addr   = k_reg;
                state_next = ST_SR_RB;
            end
            ST_SR_RB:
            begin
                rhs_re     = 1'b1;
                rhs_addr   = br_reg;
                t1_next    = rhs_q_reg;
                state_next = ST_SR_WA;
            end
            ST_SR_WA:
            begin
                rhs_we     = 1'b1;
                rhs_addr   = k_reg;
                rhs_wd     = rhs_q_reg;
                state_next = ST_SR_WB;
            end
            ST_SR_WB:
            begin
                rhs_we     = 1'b1;
                rhs_addr   = br_reg;
                rhs_wd     = t1_reg;
                state_next = ST_EL_PIV;
            end
            ST_EL_PIV:
            begin
                mat_re     = 1'b1;
                mat_addr   = {k_reg, k_reg};
                state_next = ST_EL_PW;
            end
            ST_EL_PW:
            begin
                piv_next   = mat_q_reg;
                cm_start   = 1'b1;
                state_next = ST_EL_DEN;
            end
            ST_EL_DEN:
            begin
                if (cm_done)
                begin
                    den_next = cm_res.s1[WORD_W-1:0];
                    r_next   = k_reg + 1'b1;
                    if (k_reg == nl_reg)
                        state_next = ST_K_NEXT;
                    else
                        state_next = ST_EL_RD;
                end
            end
            ST_EL_RD:
            begin
                mat_re     = 1'b1;
                mat_addr   = {r_reg, k_reg};
                state_next = ST_EL_FW;
            end
            ST_EL_FW:
            begin
                cm_start   = 1'b1;
                cm_b       = piv_reg;
                state_next = ST_EL_FN;
            end
            ST_EL_FN:
            begin
                if (cm_done)
                begin
                    dv_start   = 1'b1;
                    state_next = ST_EL_FD;
                end
            end
            ST_EL_FD:
            begin
                if (dv_done)
                begin
                    f_next     = dv_q;
                    e_next     = k_reg + 1'b1;
                    state_next = ST_EL_AR;
                end
            end
            ST_EL_AR:
            begin
                mat_re     = 1'b1;
                mat_addr   = {k_reg, e_reg};
                state_next = ST_EL_AW;
            end
            ST_EL_AW:
            begin
                cm_start   = 1'b1;
                cm_conj    = 1'b0;
                cm_a       = f_reg;
                state_next = ST_EL_AM;
            end
            ST_EL_AM:
            begin
                if (cm_done)
                begin
                    mat_re     = 1'b1;
                    mat_addr   = {r_reg, e_reg};
                    state_next = ST_EL_AS;
                end
            end
            ST_EL_AS:
            begin
                mat_we   = 1'b1;
                mat_addr = {r_reg, e_reg};
                mat_wd   = csub(mat_q_reg, prod);
                if (e_reg == nl_reg)
                    state_next = ST_EL_BR;
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_EL_AR;
                end
            end
            ST_EL_BR:
            begin
                rhs_re     = 1'b1;
                rhs_addr   = k_reg;
                state_next = ST_EL_BW;
            end
            ST_EL_BW:
            begin
                cm_start   = 1'b1;
                cm_conj    = 1'b0;
                cm_a       = f_reg;
                cm_b       = rhs_q_reg;
                state_next = ST_EL_BM;
            end
            ST_EL_BM:
            begin
                if (cm_done)
                begin
                    rhs_re     = 1'b1;
                    rhs_addr   = r_reg;
                    state_next = ST_EL_BS;
                end
            end
            ST_EL_BS:
            begin
                rhs_we   = 1'b1;
                rhs_addr = r_reg;
                rhs_wd   = csub(rhs_q_reg, prod);
                if (r_reg == nl_reg)
                    state_next = ST_K_NEXT;
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_EL_RD;
                end
            end
            ST_K_NEXT:
            begin
                if (k_reg == nl_reg)
                begin
                    r_next     = nl_reg;
                    state_next = ST_BK_RB;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    r_next     = k_reg + 1'b1;
                    br_next    = k_reg + 1'b1;
                    best_next  = '0;
                    state_next = ST_PV_RD;
                end
            end
            ST_BK_RB:
            begin
                rhs_re     = 1'b1;
                rhs_addr   = r_reg;
                state_next = ST_BK_VW;
            end
            ST_BK_VW:
            begin
                v_next = rhs_q_reg;
                e_next = r_reg + 1'b1;
                if (r_reg == nl_reg)
                    state_next = ST_BK_DR;
                else
                    state_next = ST_BK_AR;
            end
            ST_BK_AR:
            begin
                mat_re     = 1'b1;
                mat_addr   = {r_reg, e_reg};
                sol_re     = 1'b1;
                sol_addr   = e_reg;
                state_next = ST_BK_AW;
            end
            ST_BK_AW:
            begin
                cm_start   = 1'b1;
                cm_conj    = 1'b0;
                cm_b       = sol_q_reg;
                state_next = ST_BK_AM;
            end
            ST_BK_AM:
            begin
                if (cm_done)
                begin
                    v_next = csub(v_reg, prod);
                    if (e_reg == nl_reg)
                        state_next = ST_BK_DR;
                    else
                    begin
                        e_next     = e_reg + 1'b1;
                        state_next = ST_BK_AR;
                    end
                end
            end
            ST_BK_DR:
            begin
                mat_re     = 1'b1;
                mat_addr   = {r_reg, r_reg};
                state_next = ST_BK_DW;
            end
            ST_BK_DW:
            begin
                dv_next    = mat_q_reg;
                cm_start   = 1'b1;
                state_next = ST_BK_DM;
            end
            ST_BK_DM:
            begin
                cm_a = v_reg;
                cm_b = dv_reg;
                if (cm_done)
                begin
                    den_next   = cm_res.s1[WORD_W-1:0];
                    cm_start   = 1'b1;
                    state_next = ST_BK_DN;
                end
            end
            ST_BK_DN:
            begin
                if (cm_done)
                begin
                    dv_start   = 1'b1;
                    state_next = ST_BK_DD;
                end
            end
            ST_BK_DD:
            begin
                if (dv_done)
                begin
                    sol_we   = 1'b1;
                    sol_addr = r_reg;
                    sol_wd   = dv_q;
                    if (r_reg == '0)
                        state_next = ST_OUT_RD;
                    else
                    begin
                        r_next     = r_reg - 1'b1;
                        state_next = ST_BK_RB;
                    end
                end
            end
            ST_OUT_RD:
            begin
                sol_re     = 1'b1;
                sol_addr   = r_reg;
                state_next = ST_OUT_WT;
            end
            ST_OUT_WT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = r_reg;
                    out_val_next   = sol_q_reg;
                    out_sing_next  = 1'b0;
                    out_last_next  = (r_reg == nl_reg);
                    if (r_reg == nl_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        r_next     = r_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            ST_SING:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = '0;
                    out_val_next   = '0;
                    out_sing_next  = 1'b1;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            r_reg         <= '0;
            e_reg         <= '0;
            br_reg        <= '0;
            nl_reg        <= '0;
            size_reg      <= SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            r_reg         <= r_next;
            e_reg         <= e_next;
            br_reg        <= br_next;
            nl_reg        <= nl_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        t1_reg       <= t1_next;
        den_reg      <= den_next;
        piv_reg      <= piv_next;
        f_reg        <= f_next;
        v_reg        <= v_next;
        dv_reg       <= dv_next;
        out_idx_reg  <= out_idx_next;
        out_val_reg  <= out_val_next;
        out_sing_reg <= out_sing_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mat_we)
            mat_mem[mat_addr] <= mat_wd;
        if (mat_re)
            mat_q_reg <= mat_mem[mat_addr];
    end

    always_ff @(posedge clk)
    begin
        if (rhs_we)
            rhs_mem[rhs_addr] <= rhs_wd;
        if (rhs_re)
            rhs_q_reg <= rhs_mem[rhs_addr];
    end

    always_ff @(posedge clk)
    begin
        if (sol_we)
            sol_mem[sol_addr] <= sol_wd;
        if (sol_re)
            sol_q_reg <= sol_mem[sol_addr];
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {4'b0000, out_val_reg.im, out_val_reg.re, out_idx_reg};
    assign m_tuser[0] = out_sing_reg;
    assign m_tlast    = out_last_reg;

endmodule

// ----- hw/rtl/cgps_cmul.sv -----
// Sequential complex product unit: four products through one multiplier.
// Plain mode gives a*b, conjugate mode gives a*conj(b); sums are exact. Uses cgps_pkg.
module cgps_cmul (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              conj,
    input  cgps_pkg::cplx_t   a,
    input  cgps_pkg::cplx_t   b,
    output logic              done,
    output cgps_pkg::mul_res_t res
);
    import cgps_pkg::*;

    logic                     busy_reg;
    logic [2:0]               cnt_reg;
    logic                     done_reg;
    logic                     conj_reg;
    cplx_t                    a_reg;
    cplx_t                    b_reg;
    logic signed [WORD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  s1_reg;
    logic signed [SUM_W-1:0]  s2_reg;
    logic signed [DATA_W-1:0] op_x;
    logic signed [DATA_W-1:0] op_y;
    logic signed [WORD_W-1:0] product;
    logic signed [SUM_W-1:0]  prod_ext;

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:
            begin
                op_x = a_reg.re;
                op_y = b_reg.re;
            end
            2'd1:
            begin
                op_x = a_reg.im;
                op_y = b_reg.im;
            end
            2'd2:
            begin
                op_x = a_reg.re;
                op_y = b_reg.im;
            end
            default:
            begin
                op_x = a_reg.im;
                op_y = b_reg.re;
            end
        endcase
    end

    assign product  = op_x * op_y;
    assign prod_ext = {prod_reg[WORD_W-1], prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 3'd4);
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg    <= a;
            b_reg    <= b;
            conj_reg <= conj;
        end
        if (busy_reg)
        begin
            prod_reg <= product;
            unique case (cnt_reg)
                3'd1: s1_reg <= prod_ext;
                3'd2: s1_reg <= conj_reg ? s1_reg + prod_ext : s1_reg - prod_ext;
                3'd3: s2_reg <= conj_reg ? -prod_ext : prod_ext;
                3'd4: s2_reg <= s2_reg + prod_ext;
                default: ;
            endcase
        end
    end

    assign done   = done_reg;
    assign res.s1 = s1_reg;
    assign res.s2 = s2_reg;

endmodule

// ----- hw/rtl/cgps_cdiv.sv -----
// Two-lane restoring divider: num * 2^FRAC_W / den, truncated toward zero, saturated.
// One quotient bit per cycle on each lane, shared denominator. Uses cgps_pkg.
module cgps_cdiv (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [cgps_pkg::SUM_W-1:0]  num_re,
    input  logic signed [cgps_pkg::SUM_W-1:0]  num_im,
    input  logic [cgps_pkg::WORD_W-1:0]        den,
    output logic                               done,
    output cgps_pkg::cplx_t                    q
);
    import cgps_pkg::*;

    logic                     busy_reg;
    logic [DIV_CNT_W-1:0]     cnt_reg;
    logic                     done_reg;
    logic [WORD_W-1:0]        den_reg;
    logic                     zero_reg;
    logic                     neg_reg  [2];
    logic                     ovf_reg  [2];
    logic [DIV_STEPS-1:0]     dd_reg   [2];
    logic [WORD_W-1:0]        rem_reg  [2];
    logic [DATA_W-1:0]        quo_reg  [2];
    logic signed [SUM_W-1:0]  num      [2];
    logic [WORD_W-1:0]        rem_sh   [2];
    logic                     ge       [2];
    logic signed [DATA_W-1:0] lane_q   [2];

    assign num[0] = num_re;
    assign num[1] = num_im;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            rem_sh[i] = {rem_reg[i][WORD_W-2:0], dd_reg[i][DIV_STEPS-1]};
            ge[i]     = rem_sh[i] >= den_reg;
            if (zero_reg)
                lane_q[i] = '0;
            else if (ovf_reg[i] || quo_reg[i][DATA_W-1])
                lane_q[i] = neg_reg[i] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
            else
                lane_q[i] = neg_reg[i] ? -$signed(quo_reg[i]) : $signed(quo_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            den_reg  <= den;
            zero_reg <= (den == '0);
            for (int i = 0; i < 2; i++)
            begin
                logic signed [SUM_W-1:0] mag;
                mag         = num[i][SUM_W-1] ? -num[i] : num[i];
                neg_reg[i]  <= num[i][SUM_W-1];
                ovf_reg[i]  <= 1'b0;
                dd_reg[i]   <= {mag[WORD_W-1:0], {FRAC_W{1'b0}}};
                rem_reg[i]  <= '0;
                quo_reg[i]  <= '0;
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 2; i++)
            begin
                dd_reg[i]  <= {dd_reg[i][DIV_STEPS-2:0], 1'b0};
                rem_reg[i] <= ge[i] ? rem_sh[i] - den_reg : rem_sh[i];
                quo_reg[i] <= {quo_reg[i][DATA_W-2:0], ge[i]};
                ovf_reg[i] <= ovf_reg[i] | quo_reg[i][DATA_W-1];
            end
        end
    end

    assign done = done_reg;
    assign q.re = lane_q[0];
    assign q.im = lane_q[1];

endmodule

// ----- hw/rtl/cgps_checker.sv -----
// Port-level checks for the complex solver, bound to the top level.
// Sees the top-level ports only; no package needed.
module cgps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result dropped or changed while stalled");

    ap_sing_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("singular result not marked last");

    ap_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 72'd0)
        else $error("singular result carries data");

    ap_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken while a solve is still emitting");

endmodule

bind complex_gauss_partial_pivot_solve_core cgps_checker u_cgps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- sim/complex_gauss_partial_pivot_solve_core_tb.sv -----
// Testbench for complex_gauss_partial_pivot_solve_core: loads complex systems, solves them and
// checks every solution entry against a behavioural solver kept in the bench.
// Depends on cgps_pkg and the core RTL.
`timescale 1ns / 1ps

module complex_gauss_partial_pivot_solve_core_tb;
    import cgps_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [3:0]         idx;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               sing;
        logic               last;
    } sol_entry_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [71:0]         s_tdata;
    logic [OP_W-1:0]     s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [71:0]         m_tdata;
    logic [0:0]          m_tuser;
    logic                m_tlast;
    logic                cfg_we;
    logic [SIZE_W-1:0]   cfg_wdata;

    sol_entry_t expected_solutions[$];
    cplx_t      mat_model[CELLS];
    cplx_t      rhs_model[MAX_SIZE];
    cplx_t      sol_model[MAX_SIZE];
    logic [SIZE_W-1:0] size_model;

    int  mismatches;
    int  requests_sent;
    int  solves_sent;
    int  results_checked;
    bit  tx_idle;
    bit  rx_idle;
    int  hold_len;
    bit  hold_go;
    int  hold_cnt;

    complex_gauss_partial_pivot_solve_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic logic signed [31:0] clamp32(input wide_t v);
        if (v > wide_t'(32'sh7FFFFFFF))
            return 32'sh7FFFFFFF;
        if (v < -wide_t'(64'sh80000000))
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic cplx_t cx_sub(input cplx_t a, input cplx_t b);
        cplx_t r;
        wide_t ar, ai, br, bi;
        ar = a.re;
        ai = a.im;
        br = b.re;
        bi = b.im;
        r.re = clamp32(ar - br);
        r.im = clamp32(ai - bi);
        return r;
    endfunction

    function automatic cplx_t cx_mul(input cplx_t a, input cplx_t b);
        cplx_t r;
        wide_t ar, ai, br, bi;
        ar = a.re;
        ai = a.im;
        br = b.re;
        bi = b.im;
        r.re = clamp32((ar * br - ai * bi) >>> FRAC_W);
        r.im = clamp32((ar * bi + ai * br) >>> FRAC_W);
        return r;
    endfunction

    function automatic wide_t cx_mag2(input cplx_t a);
        wide_t ar, ai;
        ar = a.re;
        ai = a.im;
        return ar * ar + ai * ai;
    endfunction

    function automatic logic signed [31:0] scaled_quot(input wide_t num, input wide_t den);
        wide_t mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag <<< FRAC_W) / den;
        return clamp32((num < 0) ? -q : q);
    endfunction

    function automatic cplx_t cx_div(input cplx_t x, input cplx_t y);
        cplx_t r;
        wide_t den, xr, xi, yr, yi;
        r.re = 0;
        r.im = 0;
        den = cx_mag2(y);
        if (den == 0)
            return r;
        xr = x.re;
        xi = x.im;
        yr = y.re;
        yi = y.im;
        r.re = scaled_quot(xr * yr + xi * yi, den);
        r.im = scaled_quot(xi * yr - xr * yi, den);
        return r;
    endfunction

    function automatic void push_solution(input int idx, input cplx_t v, input bit sing,
                                          input bit last);
        sol_entry_t s;
        s.idx  = idx[3:0];
        s.re   = v.re;
        s.im   = v.im;
        s.sing = sing;
        s.last = last;
        expected_solutions.push_back(s);
    endfunction

    function automatic void solve_system();
        int    n, k, r, e, best_row;
        wide_t best, m;
        cplx_t piv, f, t, v, zero;
        zero.re = 0;
        zero.im = 0;
        n = (size_model == 0) ? 1 : ((size_model > MAX_SIZE) ? MAX_SIZE : int'(size_model));
        for (k = 0; k < n; k++)
        begin
            best = cx_mag2(mat_model[k * MAX_SIZE + k]);
            best_row = k;
            for (r = k + 1; r < n; r++)
            begin
                m = cx_mag2(mat_model[r * MAX_SIZE + k]);
                if (m > best)
                begin
                    best = m;
                    best_row = r;
                end
            end
            if (best == 0)
            begin
                push_solution(0, zero, 1'b1, 1'b1);
                return;
            end
            if (best_row != k)
            begin
                for (e = k; e < n; e++)
                begin
                    t = mat_model[k * MAX_SIZE + e];
                    mat_model[k * MAX_SIZE + e] = mat_model[best_row * MAX_SIZE + e];
                    mat_model[best_row * MAX_SIZE + e] = t;
                end
                t = rhs_model[k];
                rhs_model[k] = rhs_model[best_row];
                rhs_model[best_row] = t;
            end
            piv = mat_model[k * MAX_SIZE + k];
            for (r = k + 1; r < n; r++)
            begin
                f = cx_div(mat_model[r * MAX_SIZE + k], piv);
                for (e = k + 1; e < n; e++)
                    mat_model[r * MAX_SIZE + e] = cx_sub(mat_model[r * MAX_SIZE + e],
                                                         cx_mul(f, mat_model[k * MAX_SIZE + e]));
                rhs_model[r] = cx_sub(rhs_model[r], cx_mul(f, rhs_model[k]));
            end
        end
        for (r = n - 1; r >= 0; r--)
        begin
            v = rhs_model[r];
            for (e = r + 1; e < n; e++)
                v = cx_sub(v, cx_mul(mat_model[r * MAX_SIZE + e], sol_model[e]));
            sol_model[r] = cx_div(v, mat_model[r * MAX_SIZE + r]);
        end
        for (r = 0; r < n; r++)
            push_solution(r, sol_model[r], 1'b0, r == n - 1);
    endfunction

    function automatic void predict_request(input logic [OP_W-1:0] op, input logic [3:0] row,
                                            input logic [3:0] col, input cplx_t v);
        case (op)
            OP_WR_MAT: mat_model[row * MAX_SIZE + col] = v;
            OP_WR_RHS: rhs_model[row] = v;
            OP_SOLVE:  solve_system();
            default:   ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic send_req(input logic [OP_W-1:0] op, input logic [3:0] row,
                            input logic [3:0] col, input cplx_t v);
        while (tx_idle && $urandom_range(99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {v.im, v.re, col, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_request(op, row, col, v);
        requests_sent++;
        if (op == OP_SOLVE)
            solves_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_solutions.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        size_model = v;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic cplx_t cx(input logic signed [31:0] re, input logic signed [31:0] im);
        cplx_t r;
        r.re = re;
        r.im = im;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_part();
        int sel;
        sel = $urandom_range(99);
        if (sel < 25)
            return $urandom;
        if (sel < 80)
            return $urandom_range(0, 1 << 20) - (1 << 19);
        if (sel < 90)
            return 0;
        return ($urandom_range(1)) ? 32'sh7FFFFFFF : 32'sh80000000;
    endfunction

    // kind 0: random, 1: diagonally heavy, 2: one column held at zero
    task automatic load_system(input int n, input int kind);
        int    cells[$];
        int    i, j, tmp, zero_col, c;
        cplx_t v;
        zero_col = $urandom_range(n - 1);
        for (i = 0; i < n * n + n; i++)
            cells.push_back(i);
        for (i = cells.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = cells[i];
            cells[i] = cells[j];
            cells[j] = tmp;
        end
        foreach (cells[i])
        begin
            c = cells[i];
            v = cx(rand_part(), rand_part());
            if ($urandom_range(19) == 0)
                send_req(OP_NONE, $urandom, $urandom, cx($urandom, $urandom));
            if (c >= n * n)
                send_req(OP_WR_RHS, c - n * n, $urandom, v);
            else
            begin
                if (kind == 1 && c / n == c % n)
                    v = cx(32'sh00400000 + $urandom_range(1 << 20), $urandom_range(1 << 18));
                if (kind == 2 && c % n == zero_col)
                    v = cx(0, 0);
                send_req(OP_WR_MAT, c / n, c % n, v);
            end
        end
    endtask

    task automatic test_directed();
        cplx_t z;
        z = cx(0, 0);
        write_size(1);
        send_req(OP_WR_MAT, 0, 0, cx(32'sh00010000, 0));
        send_req(OP_WR_RHS, 0, 5, cx(32'sh00038000, 32'shFFFF0000));
        send_req(OP_SOLVE, 0, 0, z);
        send_req(OP_WR_MAT, 0, 0, cx(32'sh80000000, 32'sh7FFFFFFF));
        send_req(OP_WR_RHS, 0, 0, cx(32'sh7FFFFFFF, 32'sh80000000));
        send_req(OP_SOLVE, 15, 15, cx(32'shFFFFFFFF, 32'shFFFFFFFF));
        write_size(0);
        send_req(OP_WR_MAT, 0, 0, cx(0, 32'sh00000001));
        send_req(OP_WR_RHS, 0, 0, cx(32'sh00010000, 0));
        send_req(OP_SOLVE, 0, 0, z);
        write_size(2);
        send_req(OP_WR_MAT, 0, 0, cx(32'sh00008000, 0));
        send_req(OP_WR_MAT, 0, 1, cx(32'sh00020000, 32'sh00010000));
        send_req(OP_WR_MAT, 1, 0, cx(32'sh00030000, 32'shFFFF0000));
        send_req(OP_WR_MAT, 1, 1, cx(0, 32'sh00050000));
        send_req(OP_WR_RHS, 0, 0, cx(32'sh00010000, 32'sh00010000));
        send_req(OP_WR_RHS, 1, 0, cx(32'shFFFE0000, 0));
        send_req(OP_NONE, 1, 1, cx(32'sh12345678, 32'sh9ABCDEF0));
        send_req(OP_SOLVE, 0, 0, z);
        send_req(OP_SOLVE, 0, 0, z);
        send_req(OP_WR_MAT, 0, 0, cx(32'sh00010000, 0));
        send_req(OP_WR_MAT, 1, 0, cx(0, 32'shFFFF0000));
        send_req(OP_SOLVE, 0, 0, z);
        send_req(OP_WR_MAT, 0, 0, z);
        send_req(OP_WR_MAT, 1, 0, z);
        send_req(OP_SOLVE, 0, 0, z);
    endtask

    task automatic test_full_size_singular();
        int r;
        write_size(31);
        for (r = 0; r < MAX_SIZE; r++)
            send_req(OP_WR_MAT, r, 0, cx(0, 0));
        send_req(OP_SOLVE, 0, 0, cx(0, 0));
    endtask

    task automatic test_backpressure();
        write_size(4);
        load_system(4, 1);
        hold_len = 3000;
        hold_go  = 1'b1;
        send_req(OP_SOLVE, 0, 0, cx(0, 0));
        load_system(4, 0);
        send_req(OP_SOLVE, 0, 0, cx(0, 0));
    endtask

    task automatic test_random_systems();
        int n, kind, start;
        start = requests_sent;
        while (requests_sent - start < 400)
        begin
            tx_idle = !((requests_sent - start) > 150 && (requests_sent - start) < 230);
            rx_idle = tx_idle;
            n = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            write_size((n == 1 && $urandom_range(1)) ? 5'd0 : n[SIZE_W-1:0]);
            kind = $urandom_range(9);
            load_system(n, (kind < 5) ? 0 : ((kind < 8) ? 1 : 2));
            send_req(OP_SOLVE, $urandom, $urandom, cx($urandom, $urandom));
            if ($urandom_range(4) == 0)
                send_req(OP_SOLVE, 0, 0, cx(0, 0));
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_solutions.size() == 0)
                begin
                    $display("MISMATCH unexpected result index %0d at %0t", m_tdata[3:0], $time);
                    mismatches++;
                end
                else
                begin
                    sol_entry_t want;
                    want = expected_solutions.pop_front();
                    results_checked++;
                    if (m_tdata[3:0] !== want.idx)
                        report_mismatch("index", m_tdata[3:0], want.idx);
                    if (m_tdata[35:4] !== want.re)
                        report_mismatch("solution_real", m_tdata[35:4], want.re);
                    if (m_tdata[67:36] !== want.im)
                        report_mismatch("solution_imag", m_tdata[67:36], want.im);
                    if (m_tuser[0] !== want.sing)
                        report_mismatch("singular", m_tuser[0], want.sing);
                    if (m_tlast !== want.last)
                        report_mismatch("last", m_tlast, want.last);
                end
            end
            if (hold_go)
            begin
                hold_cnt = hold_len;
                hold_go  = 1'b0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(rx_idle && $urandom_range(99) < 17);
        end
    end

    initial
    begin
        #30ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        size_model = SIZE_RESET;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        hold_go = 1'b0;
        hold_cnt = 0;
        hold_len = 0;
        mismatches = 0;
        requests_sent = 0;
        solves_sent = 0;
        results_checked = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_size_singular();
        test_backpressure();
        test_random_systems();
        drain();
        $display("Covered %0d requests including %0d solves, %0d solution entries checked,",
                 requests_sent, solves_sent, results_checked);
        $display("sizes 0 to 31, singular systems, pivot swaps and a long output stall.");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
